// ===== sv/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes and types of the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int WORD_W    = 32;

    // request codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PEEK_BACK  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // per-request result info handed from the pointer logic to the output side
    typedef struct packed {
        logic                rd_used;
        logic [STATUS_W-1:0] status;
        logic                is_empty;
    } resp_info_t;

endpackage

// ===== sv/deq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Front pointer and occupancy of the ring buffer; decodes each request into
// at most one entry write or one entry read and the result status.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [deq_pkg::FUNC_W-1:0]      func,
    input  logic [deq_pkg::WORD_W-1:0]      data,
    output logic                            we,
    output logic [$clog2(DEPTH)-1:0]        waddr,
    output logic [DATA_WIDTH-1:0]           wdata,
    output logic                            re,
    output logic [$clog2(DEPTH)-1:0]        raddr,
    output deq_pkg::resp_info_t             info
);
    import deq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 2;

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] front_dec;
    logic [SUM_W-1:0]  sum_slot;
    logic [SUM_W-1:0]  sum_last;
    logic [ADDR_W-1:0] back_slot;
    logic [ADDR_W-1:0] back_last;
    logic [63:0]       data_ext;
    logic              full;
    logic              empty;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign sum_slot  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign sum_last  = sum_slot - 1'b1;
    assign back_slot = (sum_slot >= SUM_W'(DEPTH)) ? ADDR_W'(sum_slot - SUM_W'(DEPTH))
                                                   : sum_slot[ADDR_W-1:0];
    assign back_last = (sum_last >= SUM_W'(DEPTH)) ? ADDR_W'(sum_last - SUM_W'(DEPTH))
                                                   : sum_last[ADDR_W-1:0];

    assign data_ext = {32'b0, data};
    assign wdata    = data_ext[DATA_WIDTH-1:0];

    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        we           = 1'b0;
        waddr        = back_slot;
        re           = 1'b0;
        raddr        = front_reg;
        info.rd_used = 1'b0;
        info.status  = ST_OK;
        case (func) inside
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (full)
                begin
                    info.status = ST_FULL;
                end
                else
                begin
                    we         = accept;
                    count_next = count_reg + 1'b1;
                    if (func == FN_PUSH_FRONT)
                    begin
                        front_next = front_dec;
                        waddr      = front_dec;
                    end
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK:
            begin
                if (empty)
                begin
                    info.status = ST_EMPTY;
                end
                else
                begin
                    re           = accept;
                    info.rd_used = 1'b1;
                    if (func == FN_POP_BACK || func == FN_PEEK_BACK)
                    begin
                        raddr = back_last;
                    end
                    if (func == FN_POP_FRONT)
                    begin
                        front_next = (front_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                       : front_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else if (func == FN_POP_BACK)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                // unused code: leave the queue untouched
                front_next = front_reg;
            end
        endcase
        info.is_empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re))
        else $error("write and read in one request");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && info.status == ST_FULL) |=> $stable(count_reg) && $stable(front_reg))
        else $error("dropped push changed the queue");
`endif

endmodule

// ===== sv/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of data words kept as a ring buffer in RAM.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while the master side keeps up. Each
// request gives one result: the edge that takes the request registers the
// entry RAM read, and the result then moves into the output register,
// where it becomes valid on the master side. A result held on
// the master side stalls the input once the read stage behind it is also
// occupied. Pointer and occupancy update at acceptance, so a request may
// touch an entry written by the request just before it. Pop or peek on an
// empty queue returns the empty status; push on a full queue returns the
// full status and drops the word. The entry RAM needs no clearing after reset.
module double_ended_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [deq_pkg::WORD_W-1:0]        s_axis_tdata,  // [31:0] data
    input  logic [deq_pkg::FUNC_W-1:0]        s_axis_tuser,  // [2:0] func
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [deq_pkg::WORD_W-1:0]        m_axis_tdata,  // [31:0] value
    output logic [deq_pkg::STATUS_W:0]        m_axis_tuser   // [1:0] status, [2] is_empty
);
    import deq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic                  accept;
    logic                  out_free;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
    logic [DATA_WIDTH-1:0] rdata;
    logic [63:0]           rd_ext;
    resp_info_t            info;

    logic                  s1_valid_reg, s1_valid_next;
    resp_info_t            s1_info_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]     out_value_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_empty_reg;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .func   (s_axis_tuser),
        .data   (s_axis_tdata),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .re     (re),
        .raddr  (raddr),
        .info   (info)
    );

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_ext = 64'(rdata);

    // read data stays put while stage one is stalled: no new read is issued
    assign s1_valid_next  = accept || (s1_valid_reg && !out_free);
    assign out_valid_next = out_free ? s1_valid_reg : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
        if (out_free && s1_valid_reg)
        begin
            out_value_reg  <= s1_info_reg.rd_used ? rd_ext[WORD_W-1:0] : '0;
            out_status_reg <= s1_info_reg.status;
            out_empty_reg  <= s1_info_reg.is_empty;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {out_empty_reg, out_status_reg};

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free slot");

    a_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        re |=> s1_valid_reg)
        else $error("entry read without a pending result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_value_reg == '0))
        else $error("error result carries a value");
`endif

endmodule
